@@ sv/dqp_pkg.sv @@
`default_nettype none

package dqp_pkg;

  localparam int MaxIntDigitIndex = 6;
  localparam int CountW           = 16;

  localparam int ChW       = 8;
  localparam int ValueW    = 32;
  localparam int ConsumedW = 16;
  localparam int DigitW    = 4;

  localparam int FracBits  = 12;
  localparam int SigDigits = 4;
  localparam int SigScale  = 10000;

  localparam int FracAccW = $clog2(SigScale);
  localparam int FracCntW = $clog2(SigDigits + 2);
  localparam int QuotW    = FracBits + 1;
  localparam int MidW     = FracBits + 1;
  localparam int DivW     = FracAccW + FracBits;
  localparam int IntCntW  = $clog2(MaxIntDigitIndex + 2);
  localparam int IntAccW  = $clog2(10 ** (MaxIntDigitIndex + 1));
  localparam int MagW     = IntAccW + FracBits + 1;

  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    CL_DIGIT,
    CL_MINUS,
    CL_POINT,
    CL_END,
    CL_OTHER
  } dqp_cls_e;

  typedef struct packed {
    dqp_cls_e          cls;
    logic [DigitW-1:0] digit;
  } dqp_item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIGN,
    PH_INT,
    PH_FRAC
  } dqp_phase_e;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_DIV,
    BK_MID,
    BK_MDIG,
    BK_FIN
  } dqp_bk_e;

  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     dividend;
    logic [FracAccW-1:0] divisor;
  } dqp_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } dqp_div_rsp_t;

  function automatic logic [FracAccW-1:0] pow10(input logic [FracCntW-1:0] n);
    logic [FracAccW-1:0] r;
    unique case (n)
      FracCntW'(0): r = FracAccW'(1);
      FracCntW'(1): r = FracAccW'(10);
      FracCntW'(2): r = FracAccW'(100);
      FracCntW'(3): r = FracAccW'(1000);
      default:      r = FracAccW'(SigScale);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/dqp_front.sv @@
`default_nettype none

module dqp_front (
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [dqp_pkg::ChW-1:0] ch_i,
  input  wire logic                   text_end_i,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output dqp_pkg::dqp_item_t          item_o
);
  import dqp_pkg::*;

  localparam logic [ChW-1:0] CharZero  = 8'h30;
  localparam logic [ChW-1:0] CharNine  = 8'h39;
  localparam logic [ChW-1:0] CharMinus = 8'h2D;
  localparam logic [ChW-1:0] CharPoint = 8'h2E;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.digit = ch_i[DigitW-1:0];
    if (text_end_i) begin
      item_o.cls = CL_END;
    end else if (ch_i >= CharZero && ch_i <= CharNine) begin
      item_o.cls = CL_DIGIT;
    end else if (ch_i == CharMinus) begin
      item_o.cls = CL_MINUS;
    end else if (ch_i == CharPoint) begin
      item_o.cls = CL_POINT;
    end else begin
      item_o.cls = CL_OTHER;
    end
  end

endmodule

`default_nettype wire

@@ sv/dqp_queue.sv @@
`default_nettype none

module dqp_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire dqp_pkg::dqp_item_t item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output dqp_pkg::dqp_item_t      item_o
);
  import dqp_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  dqp_item_t       mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dqp_div.sv @@
`default_nettype none

module dqp_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dqp_pkg::dqp_div_req_t req_i,
  output dqp_pkg::dqp_div_rsp_t      rsp_o
);
  import dqp_pkg::*;

  localparam int StepW = $clog2(QuotW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [FracAccW-1:0] rem_q, rem_d;
  logic [FracAccW-1:0] den_q, den_d;
  logic [QuotW-1:0]    sh_q, sh_d;

  logic [FracAccW:0]   trial;
  logic                ge;

  // restoring division, one quotient bit per cycle; dividend < divisor << QuotW
  assign trial = {rem_q, sh_q[QuotW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = FracAccW'(req_i.dividend[DivW-1:QuotW]);
      sh_d   = req_i.dividend[QuotW-1:0];
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? FracAccW'(trial - {1'b0, den_q}) : trial[FracAccW-1:0];
      sh_d   = {sh_q[QuotW-2:0], ge};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(QuotW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

`default_nettype wire

@@ sv/dqp_back.sv @@
`default_nettype none

module dqp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  input  wire dqp_pkg::dqp_item_t            item_i,
  output logic                               pop_o,
  output dqp_pkg::dqp_div_req_t              div_req_o,
  input  wire dqp_pkg::dqp_div_rsp_t         div_rsp_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               ok_o,
  output logic signed [dqp_pkg::ValueW-1:0]  value_o,
  output logic [dqp_pkg::ConsumedW-1:0]      consumed_o
);
  import dqp_pkg::*;

  localparam int TW = QuotW + 1 + FracAccW;

  dqp_bk_e             bk_q, bk_d;
  dqp_phase_e          phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [IntAccW-1:0]  int_acc_q, int_acc_d;
  logic [IntCntW-1:0]  int_cnt_q, int_cnt_d;
  logic [FracCntW-1:0] frac_cnt_q, frac_cnt_d;
  logic [FracAccW-1:0] frac_acc_q, frac_acc_d;
  logic [QuotW-1:0]    rfrac_q, rfrac_d;
  logic [MidW-1:0]     mrem_q, mrem_d;
  logic                decided_q, decided_d;
  logic [CountW-1:0]   char_cnt_q, char_cnt_d;
  logic [DigitW-1:0]   dig_q, dig_d;

  logic                 out_valid_q, out_valid_d;
  logic                 ok_q, ok_d;
  logic [ValueW-1:0]    value_q, value_d;
  logic [ConsumedW-1:0] consumed_q, consumed_d;

  logic                slot_free;
  logic [CountW-1:0]   cnt_inc;
  logic [DigitW-1:0]   mid_dig;
  logic [MidW+3:0]     mid_mul;
  logic [DigitW-1:0]   mid_td;
  logic [FracAccW-1:0] den;
  logic [TW-1:0]       tmul;
  logic [QuotW-1:0]    frac_v;
  logic [MagW-1:0]     mag;
  logic [63:0]         mag64, neg64;
  logic                range_bad;
  logic                fin_go, fail, emit_ok, clr, mid_go;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = (bk_q == BK_RUN) && !q_empty_i && slot_free;
  assign cnt_inc   = (&char_cnt_q) ? char_cnt_q : char_cnt_q + CountW'(1);

  // next decimal digit of the midpoint between the two rounding candidates
  assign mid_dig = (bk_q == BK_MDIG) ? dig_q : item_i.digit;
  assign mid_mul = (MidW+4)'(mrem_q) * (MidW+4)'(10);
  assign mid_td  = mid_mul[MidW+3:MidW];

  assign den  = pow10(frac_cnt_q);
  assign tmul = (TW'({div_rsp_i.quot, 1'b1})) * TW'(SigScale);

  assign frac_v = (frac_cnt_q == FracCntW'(SigDigits + 1)) ? rfrac_q : div_rsp_i.quot;
  assign mag    = {int_acc_q, {FracBits{1'b0}}} + MagW'(frac_v);
  assign mag64  = 64'(mag);
  assign neg64  = 64'(0) - mag64;
  assign range_bad = neg_q ? (mag64 > 64'h8000_0000) : (mag64 > 64'h7FFF_FFFF);

  assign div_req_o.dividend = {frac_acc_q, {FracBits{1'b0}}} + DivW'(den >> 1);
  assign div_req_o.divisor  = den;

  always_comb begin
    bk_d       = bk_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    int_acc_d  = int_acc_q;
    int_cnt_d  = int_cnt_q;
    frac_cnt_d = frac_cnt_q;
    frac_acc_d = frac_acc_q;
    rfrac_d    = rfrac_q;
    mrem_d     = mrem_q;
    decided_d  = decided_q;
    char_cnt_d = char_cnt_q;
    dig_d      = dig_q;
    div_req_o.start = 1'b0;
    fin_go  = 1'b0;
    fail    = 1'b0;
    emit_ok = 1'b0;
    mid_go  = 1'b0;

    unique case (bk_q)
      BK_RUN: begin
        if (pop_o) begin
          unique case (phase_q)
            PH_IDLE, PH_SIGN: begin
              unique case (item_i.cls)
                CL_MINUS: begin
                  if (phase_q == PH_IDLE) begin
                    neg_d      = 1'b1;
                    char_cnt_d = cnt_inc;
                    phase_d    = PH_SIGN;
                  end else begin
                    fail = 1'b1;
                  end
                end
                CL_DIGIT: begin
                  int_acc_d  = IntAccW'(item_i.digit);
                  int_cnt_d  = IntCntW'(1);
                  char_cnt_d = cnt_inc;
                  phase_d    = PH_INT;
                end
                CL_POINT: begin
                  char_cnt_d = cnt_inc;
                  phase_d    = PH_FRAC;
                end
                default: fail = 1'b1;
              endcase
            end
            PH_INT: begin
              unique case (item_i.cls)
                CL_DIGIT: begin
                  if (int_cnt_q > IntCntW'(MaxIntDigitIndex)) begin
                    fail = 1'b1;
                  end else begin
                    int_acc_d  = int_acc_q * IntAccW'(10) + IntAccW'(item_i.digit);
                    int_cnt_d  = int_cnt_q + IntCntW'(1);
                    char_cnt_d = cnt_inc;
                  end
                end
                CL_POINT: begin
                  char_cnt_d = cnt_inc;
                  phase_d    = PH_FRAC;
                end
                default: fin_go = 1'b1;
              endcase
            end
            PH_FRAC: begin
              if (item_i.cls == CL_DIGIT) begin
                char_cnt_d = cnt_inc;
                if (frac_cnt_q < FracCntW'(SigDigits)) begin
                  frac_acc_d = frac_acc_q * FracAccW'(10) + FracAccW'(item_i.digit);
                  frac_cnt_d = frac_cnt_q + FracCntW'(1);
                end else if (frac_cnt_q == FracCntW'(SigDigits)) begin
                  // first digit past the significant ones: round what we have
                  frac_cnt_d      = FracCntW'(SigDigits + 1);
                  dig_d           = item_i.digit;
                  div_req_o.start = 1'b1;
                  bk_d            = BK_DIV;
                end else if (!decided_q) begin
                  mid_go = 1'b1;
                end
              end else begin
                fin_go = 1'b1;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
      BK_DIV: begin
        if (div_rsp_i.done) begin
          bk_d = (frac_cnt_q == FracCntW'(SigDigits + 1)) ? BK_MID : BK_FIN;
        end
      end
      BK_MID: begin
        rfrac_d = div_rsp_i.quot;
        mrem_d  = tmul[MidW-1:0];
        if (tmul[TW-1:MidW] != (TW-MidW)'(frac_acc_q)) begin
          decided_d = 1'b1;
          bk_d      = BK_RUN;
        end else begin
          bk_d = BK_MDIG;
        end
      end
      BK_MDIG: begin
        mid_go = 1'b1;
        bk_d   = BK_RUN;
      end
      BK_FIN: begin
        bk_d = BK_RUN;
        if (range_bad) begin
          fail = 1'b1;
        end else begin
          emit_ok = 1'b1;
        end
      end
      default: bk_d = BK_RUN;
    endcase

    if (mid_go) begin
      if (mid_td != mid_dig) begin
        if (mid_dig > mid_td) begin
          rfrac_d = rfrac_q + QuotW'(1);
        end
        decided_d = 1'b1;
      end else begin
        mrem_d = mid_mul[MidW-1:0];
      end
    end

    if (fin_go) begin
      if (phase_q == PH_FRAC && int_cnt_q == '0 && frac_cnt_q == '0) begin
        fail = 1'b1;
      end else if (frac_cnt_q == FracCntW'(SigDigits + 1)) begin
        bk_d = BK_FIN;
      end else begin
        div_req_o.start = 1'b1;
        bk_d            = BK_DIV;
      end
    end

    clr = fail || emit_ok;
    if (clr) begin
      phase_d    = PH_IDLE;
      neg_d      = 1'b0;
      int_acc_d  = '0;
      int_cnt_d  = '0;
      frac_cnt_d = '0;
      frac_acc_d = '0;
      rfrac_d    = '0;
      mrem_d     = '0;
      decided_d  = 1'b0;
      char_cnt_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d        = ok_q;
    value_d     = value_q;
    consumed_d  = consumed_q;
    if (clr) begin
      out_valid_d = 1'b1;
      ok_d        = emit_ok;
      value_d     = emit_ok ? (neg_q ? neg64[ValueW-1:0] : mag64[ValueW-1:0]) : '0;
      consumed_d  = emit_ok ? ConsumedW'(char_cnt_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bk_q        <= BK_RUN;
      phase_q     <= PH_IDLE;
      neg_q       <= 1'b0;
      int_acc_q   <= '0;
      int_cnt_q   <= '0;
      frac_cnt_q  <= '0;
      frac_acc_q  <= '0;
      rfrac_q     <= '0;
      mrem_q      <= '0;
      decided_q   <= 1'b0;
      char_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bk_q        <= bk_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      int_acc_q   <= int_acc_d;
      int_cnt_q   <= int_cnt_d;
      frac_cnt_q  <= frac_cnt_d;
      frac_acc_q  <= frac_acc_d;
      rfrac_q     <= rfrac_d;
      mrem_q      <= mrem_d;
      decided_q   <= decided_d;
      char_cnt_q  <= char_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q      <= dig_d;
    ok_q       <= ok_d;
    value_q    <= value_d;
    consumed_q <= consumed_d;
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign value_o     = value_q;
  assign consumed_o  = consumed_q;

  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_q == BK_FIN) |-> !out_valid_q)
    else $error("result register busy at finish");

  a_frac_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_cnt_q <= FracCntW'(SigDigits + 1))
    else $error("fraction digit count out of range");

  a_int_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int_cnt_q <= IntCntW'(MaxIntDigitIndex + 1))
    else $error("integer digit count out of range");

  a_decided_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decided_q |-> (frac_cnt_q == FracCntW'(SigDigits + 1)))
    else $error("rounding decided before fifth fraction digit");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (char_cnt_q == '0 && !neg_q))
    else $error("idle with stale number state");

endmodule

`default_nettype wire

@@ sv/decimal_to_q12_fixed_parser_unit.sv @@
// Characters enter a 2-entry queue; 1 character per cycle is parsed unless the divider,
// rounding or a full output register holds the parser. The fifth fraction digit starts a
// 13-step restoring divider run. A terminating character's result is registered via a
// finish state, after the divider if needed, or in the cycle after a failing character.
// Reset (rst_ni low, asynchronous) empties the queue and returns the parser to idle.
`default_nettype none

module decimal_to_q12_fixed_parser_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dqp_pkg::ChW-1:0]       ch_i,
  input  wire logic                          text_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               ok_o,
  output logic signed [dqp_pkg::ValueW-1:0]  value_o,
  output logic [dqp_pkg::ConsumedW-1:0]      consumed_o
);
  import dqp_pkg::*;

  dqp_item_t    push_item, pop_item;
  logic         push, pop, q_full, q_empty;
  dqp_div_req_t div_req;
  dqp_div_rsp_t div_rsp;

  dqp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .text_end_i (text_end_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  dqp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  dqp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dqp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .value_o     (value_o),
    .consumed_o  (consumed_o)
  );

endmodule

`default_nettype wire
